### src/ptre_pkg.sv
// ----------------------------------------------------------------------------
// ptre_pkg: shared types and constants
// Transaction payload structs, field widths and opcodes for the rectangle edge
// distance block.
// ----------------------------------------------------------------------------
package ptre_pkg;

  localparam int unsigned MAX_RECTS_DEF = 16;
  localparam int unsigned COORD_W       = 16;
  localparam int unsigned DIST_W        = 21;
  localparam int unsigned CNT_W         = 5;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [3:0]  slot;
    logic [15:0] rect_x;
    logic [15:0] rect_y;
    logic [15:0] rect_w;
    logic [15:0] rect_h;
    logic [15:0] point_x;
    logic [15:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic [20:0] distance;
    logic        found;
  } out_item_t;

endpackage

### src/ptre_ram.sv
// ----------------------------------------------------------------------------
// ptre_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ptre_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/point_to_rectangle_edge_distance.sv
// ----------------------------------------------------------------------------
// point_to_rectangle_edge_distance
// Minimum distance from a point to the edges of a table of rectangles.
// ----------------------------------------------------------------------------
// Usage: write transactions (opcode 0) store one rectangle in the table at
// slot when they are accepted. They give no result and pass through S_WR.
// Query transactions (opcode 1) carry a point. The block walks all the edges
// of each of the first n = min(rect_count, MAX_RECTS) entries and returns one
// result with the minimum distance in Q17.4, or all ones with found = 0 when
// no edge qualifies.
// From acceptance to out_valid a query goes through these steps: per rectangle
// a table read, a load and then an edge step for each edge on shared squarers
// and compare logic, then a final count check, a bit-serial square root that
// builds a 22-bit root, and the fill of the output register. in_ready is low
// while a transaction is being worked on and returns as the result enters the
// output register, so a new query is accepted only after the last one has its
// result there. The result waits in the output register until taken. A later
// query that finishes while it is still full holds in its last step with in_ready low.
// Reset clears rect_count and the control state; table entries are undefined
// until written. cfg_we may be raised only while the block is idle.
// ----------------------------------------------------------------------------
module point_to_rectangle_edge_distance
  import ptre_pkg::*;
#(
  parameter int unsigned MAX_RECTS = MAX_RECTS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data
);

  localparam int unsigned AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int unsigned IW = $clog2(MAX_RECTS + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RD    = 7'b0000010,
    S_LOAD  = 7'b0000100,
    S_EDGE  = 7'b0001000,
    S_SQRT  = 7'b0010000,
    S_OUT   = 7'b0100000,
    S_WR    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] rect_count_r;
  logic [IW-1:0]    n_lim;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [1:0]       edge_r, edge_nxt;
  logic [15:0]      px_r, py_r;
  logic [17:0]      x0_r, y0_r, x1_r, y1_r;
  logic [15:0]      w_r, h_r;
  logic             found_r, found_nxt;
  logic [34:0]      best_r, best_nxt;
  logic [23:0]      rem_r, rem_nxt;
  logic [21:0]      root_r, root_nxt;
  logic [4:0]       step_r, step_nxt;
  logic [43:0]      val_r, val_nxt;
  out_item_t        out_r;
  logic             out_valid_r;
  logic [63:0]      rdata;
  logic             we;
  logic [AW-1:0]    raddr;

  // Effective count clamps at the table depth.
  always_comb begin
    if (32'(rect_count_r) > MAX_RECTS) begin
      n_lim = IW'(MAX_RECTS);
    end else begin
      n_lim = IW'(rect_count_r);
    end
  end

  // A write transaction goes into the table at the edge that accepts it.
  assign we    = (state_r == S_IDLE) && in_valid && (in_data.opcode == OP_WRITE) &&
                 (32'(in_data.slot) < MAX_RECTS);
  assign raddr = idx_r[AW-1:0];

  ptre_ram #(.WIDTH(64), .DEPTH(MAX_RECTS)) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(AW'(in_data.slot)),
    .wdata({in_data.rect_x, in_data.rect_y, in_data.rect_w, in_data.rect_h}),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Edge geometry: start corner a, along-axis offset and span.
  logic signed [18:0] ox, oy, along, perp;
  logic        [16:0] span;
  logic signed [18:0] num;
  logic        [37:0] s_perp, s_corner;
  logic        [37:0] s_edge;
  logic               qual;

  always_comb begin
    unique case (edge_r)
      2'd0: begin
        ox = 19'(signed'({1'b0, px_r})) - 19'(signed'({1'b0, x0_r}));
        oy = 19'(signed'({1'b0, py_r})) - 19'(signed'({1'b0, y0_r}));
        num = ox; span = {1'b0, w_r}; perp = oy; along = ox;
      end
      2'd1: begin
        ox = 19'(signed'({1'b0, px_r})) - 19'(signed'({1'b0, x1_r}));
        oy = 19'(signed'({1'b0, py_r})) - 19'(signed'({1'b0, y0_r}));
        num = oy; span = {1'b0, h_r}; perp = ox; along = oy;
      end
      2'd2: begin
        ox = 19'(signed'({1'b0, px_r})) - 19'(signed'({1'b0, x1_r}));
        oy = 19'(signed'({1'b0, py_r})) - 19'(signed'({1'b0, y1_r}));
        num = -ox; span = {1'b0, w_r}; perp = oy; along = ox;
      end
      default: begin
        ox = 19'(signed'({1'b0, px_r})) - 19'(signed'({1'b0, x0_r}));
        oy = 19'(signed'({1'b0, py_r})) - 19'(signed'({1'b0, y1_r}));
        num = -oy; span = {1'b0, h_r}; perp = ox; along = oy;
      end
    endcase
    s_perp   = 38'(perp * perp);
    s_corner = 38'(along * along) + s_perp;
    // Sign of num matches sign of num*|d|; compare against span equals num>den.
    if (span == 17'd0 || num < 0) begin
      qual = 1'b1; s_edge = s_corner;
    end else if (num > 19'(signed'({2'b0, span}))) begin
      qual = 1'b0; s_edge = s_perp;
    end else begin
      qual = 1'b1; s_edge = s_perp;
    end
  end

  // Bit-serial square root trial.
  logic [25:0] trial;
  logic [25:0] cur;
  always_comb begin
    cur   = {rem_r, val_r[43:42]};
    trial = {2'b00, root_r, 2'b01};
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    edge_nxt  = edge_r;
    found_nxt = found_r;
    best_nxt  = best_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    step_nxt  = step_r;
    val_nxt   = val_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.opcode == OP_QUERY) begin
            state_nxt = S_RD;
            idx_nxt   = '0;
            found_nxt = 1'b0;
          end else begin
            state_nxt = S_WR;
          end
        end
      end
      S_WR: state_nxt = S_IDLE;
      S_RD: begin
        if (idx_r >= n_lim) begin
          state_nxt = S_SQRT;
          rem_nxt   = '0;
          root_nxt  = '0;
          step_nxt  = '0;
          val_nxt   = {1'b0, best_r, 8'd0};
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        state_nxt = S_EDGE;
        edge_nxt  = 2'd0;
      end
      S_EDGE: begin
        // Squared distances fit in 35 bits (at most 2 * 131070^2).
        if (qual && (!found_r || s_edge < 38'(best_r))) begin
          best_nxt  = 35'(s_edge);
          found_nxt = 1'b1;
        end
        edge_nxt = edge_r + 2'd1;
        if (edge_r == 2'd3) begin
          state_nxt = S_RD;
          idx_nxt   = idx_r + IW'(1);
        end
      end
      S_SQRT: begin
        val_nxt = {val_r[41:0], 2'b00};
        if (cur >= trial) begin
          rem_nxt  = 24'(cur - trial);
          root_nxt = {root_r[20:0], 1'b1};
        end else begin
          rem_nxt  = 24'(cur);
          root_nxt = {root_r[20:0], 1'b0};
        end
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd21) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rect_count_r <= '0;
      out_valid_r  <= 1'b0;
      found_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      found_r <= found_nxt;
      if (cfg_we) begin
        rect_count_r <= cfg_data;
      end
      if (state_r == S_OUT && !out_valid_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    edge_r <= edge_nxt;
    best_r <= best_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    step_r <= step_nxt;
    val_r  <= val_nxt;
    if (state_r == S_IDLE) begin
      px_r <= in_data.point_x;
      py_r <= in_data.point_y;
    end
    if (state_r == S_LOAD) begin
      x0_r <= {2'b0, rdata[63:48]};
      y0_r <= {2'b0, rdata[47:32]};
      w_r  <= rdata[31:16];
      h_r  <= rdata[15:0];
      x1_r <= {2'b0, rdata[63:48]} + {2'b0, rdata[31:16]};
      y1_r <= {2'b0, rdata[47:32]} + {2'b0, rdata[15:0]};
    end
    // A root above the 21-bit range saturates to all ones.
    if (state_r == S_OUT && !out_valid_r) begin
      out_r.found    <= found_r;
      out_r.distance <= (found_r && !root_r[21]) ? root_r[20:0] : '1;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### test/tb_point_to_rectangle_edge_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_to_rectangle_edge_distance
// Self-checking bench for the rectangle edge distance block. It loads the
// table, walks several table sizes and random queries under handshake idling,
// and checks each result against a predictor of the edge search.
// ----------------------------------------------------------------------------
module tb_point_to_rectangle_edge_distance;
  import ptre_pkg::*;

  localparam int unsigned NRECT     = MAX_RECTS_DEF;
  localparam int unsigned IN_W      = $bits(in_item_t);
  localparam logic [20:0] DIST_ALL1 = 21'h1FFFFF;
  localparam int          CYC_LIMIT = 1500000;
  localparam int          DRAIN_CYC = 200;

  // Scoreboard: a copy of the rectangle table and the count, plus the queue of
  // expected query results.
  class dist_scoreboard;
    logic [15:0] rx[NRECT];
    logic [15:0] ry[NRECT];
    logic [15:0] rw[NRECT];
    logic [15:0] rh[NRECT];
    int unsigned count_reg;
    out_item_t   pending_q[$];
    int          errors;
    int          checked;

    function void set_count(logic [CNT_W-1:0] v);
      count_reg = v;
    endfunction

    // Squared distance to one edge, or -1 when the edge is skipped.
    function longint edge_sq(longint ax, longint ay, longint dx, longint dy,
                             longint px, longint py);
      longint ox, oy, num, den;
      ox  = px - ax;
      oy  = py - ay;
      num = ox * dx + oy * dy;
      den = dx * dx + dy * dy;
      if (den == 0 || num < 0) return ox * ox + oy * oy;
      if (num > den) return -1;
      if (dy == 0) return oy * oy;
      return ox * ox;
    endfunction

    function longint floor_sqrt(longint v);
      longint lo, hi, mid;
      lo = 0;
      hi = 64'd3037000499;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        if (mid * mid <= v) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    endfunction

    // Note an accepted input transaction.
    function void note_input(in_item_t it);
      int unsigned n;
      longint x0, y0, x1, y1, s, best, d;
      longint ex[4], ey[4], edx[4], edy[4];
      bit hit;
      out_item_t r;
      if (it.opcode == OP_WRITE) begin
        rx[it.slot] = it.rect_x;
        ry[it.slot] = it.rect_y;
        rw[it.slot] = it.rect_w;
        rh[it.slot] = it.rect_h;
        return;
      end
      n = (count_reg > NRECT) ? NRECT : count_reg;
      hit = 0;
      best = 0;
      for (int i = 0; i < n; i++) begin
        x0 = rx[i]; y0 = ry[i];
        x1 = x0 + rw[i]; y1 = y0 + rh[i];
        ex[0] = x0; ey[0] = y0; edx[0] = rw[i];  edy[0] = 0;
        ex[1] = x1; ey[1] = y0; edx[1] = 0;      edy[1] = rh[i];
        ex[2] = x1; ey[2] = y1; edx[2] = -rw[i]; edy[2] = 0;
        ex[3] = x0; ey[3] = y1; edx[3] = 0;      edy[3] = -rh[i];
        for (int e = 0; e < 4; e++) begin
          s = edge_sq(ex[e], ey[e], edx[e], edy[e], it.point_x, it.point_y);
          if (s >= 0 && (!hit || s < best)) begin
            best = s;
            hit = 1;
          end
        end
      end
      if (hit) begin
        d = floor_sqrt(best * 256);
        r.distance = (d > DIST_ALL1) ? DIST_ALL1 : d[20:0];
        r.found = 1'b1;
      end else begin
        r.distance = DIST_ALL1;
        r.found = 1'b0;
      end
      pending_q = {pending_q, r};
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(out_item_t got);
      out_item_t exp_r;
      checked++;
      if (pending_q.size() == 0) begin
        $error("result with no expected transaction: distance %0d found %0d",
               got.distance, got.found);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.distance !== exp_r.distance) begin
        $error("distance: expected %0d, actual %0d", exp_r.distance, got.distance);
        errors++;
      end
      if (got.found !== exp_r.found) begin
        $error("found: expected %0d, actual %0d", exp_r.found, got.found);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_data;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_data;

  dist_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_cycles;
  int cycle_cnt;
  int written_upto;

  point_to_rectangle_edge_distance uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYC_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: checks, random stalls and a long hold-off when requested.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one transaction and wait until it is accepted. Valid stays high
  // after acceptance until the next transaction or a drain replaces it.
  task automatic send_item(in_item_t it);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
  endtask

  task automatic write_rect(int slot, logic [15:0] x, logic [15:0] y,
                            logic [15:0] w, logic [15:0] h);
    in_item_t it;
    it = in_item_t'(IN_W'({$urandom, $urandom, $urandom, $urandom}));
    it.opcode = OP_WRITE;
    it.slot = 4'(slot);
    it.rect_x = x; it.rect_y = y; it.rect_w = w; it.rect_h = h;
    send_item(it);
  endtask

  task automatic query(logic [15:0] px, logic [15:0] py);
    in_item_t it;
    it = in_item_t'(IN_W'({$urandom, $urandom, $urandom, $urandom}));
    it.opcode = OP_QUERY;
    it.point_x = px; it.point_y = py;
    send_item(it);
  endtask

  // Wait until every result is in, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic set_count(logic [CNT_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    sb.set_count(v);
    cfg_we <= 1'b0;
  endtask

  // Random coordinate, mostly near a common area, sometimes at the extremes.
  function automatic logic [15:0] rnd_coord();
    unique case ($urandom_range(9))
      0: return 16'hFFFF;
      1: return 16'h0000;
      2, 3: return 16'($urandom);
      default: return 16'(16'd1000 + $urandom_range(2000));
    endcase
  endfunction

  function automatic logic [15:0] rnd_size();
    unique case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(800));
    endcase
  endfunction

  task automatic random_phase(int items, int idle, int stall);
    int s;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int k = 0; k < items; k++) begin
      if ($urandom_range(3) == 0) begin
        // Slots past the last written one are written only in order, so
        // nothing unwritten is ever read.
        s = $urandom_range(written_upto < NRECT ? written_upto : NRECT - 1);
        write_rect(s, rnd_coord(), rnd_coord(), rnd_size(), rnd_size());
        if (s == written_upto && written_upto < NRECT) written_upto++;
      end else begin
        query(rnd_coord(), rnd_coord());
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    cycle_cnt = 0;
    hold_off_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    written_upto = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table gives no edge, then edges, corners and limits.
    query(16'd100, 16'd100);
    write_rect(0, 16'd160, 16'd160, 16'd320, 16'd160);
    write_rect(1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_rect(2, 16'd500, 16'd500, 16'd0, 16'd0);
    write_rect(3, 16'd0, 16'd0, 16'd0, 16'd0);
    written_upto = 4;
    set_count(5'd1);
    query(16'd320, 16'd0);      // above the top edge
    query(16'd0, 16'd0);        // before the start corner
    query(16'd160, 16'd160);    // on the corner, projection at zero
    query(16'd480, 16'd160);    // projection at the edge end
    query(16'd320, 16'd240);    // inside
    query(16'hFFFF, 16'hFFFF);
    set_count(5'd3);            // includes a zero-size rectangle
    query(16'd500, 16'd500);
    query(16'd0, 16'hFFFF);
    set_count(5'd2);
    query(16'd0, 16'd0);        // large distance from the far rectangle
    for (int i = 4; i < NRECT; i++)
      write_rect(i, rnd_coord(), rnd_coord(), rnd_size(), rnd_size());
    written_upto = NRECT;
    set_count(5'd31);           // above the table size
    query(16'd1234, 16'd2345);
    set_count(5'd16);
    query(16'hFFFF, 16'd0);
    set_count(5'd0);
    query(16'd7, 16'd7);

    // Random phases over several table sizes and handshake idling.
    set_count(5'd4);
    random_phase(130, 0, 0);
    set_count(5'd16);
    random_phase(130, 62, 0);
    set_count(5'd1);
    random_phase(130, 0, 62);
    set_count(5'd9);
    random_phase(130, 37, 37);

    // Long receiver hold-off while the sender keeps offering.
    set_count(5'd20);
    hold_off_cycles = 400;
    random_phase(130, 0, 0);

    drain();
    $display("Covered %0d results over table sizes 0 to 16 and above, with idling.",
             sb.checked);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
